@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies property in the same cycle
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// condition implies property in the next cycle
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ sv/pvrt_pkg.sv @@
// ---------------------------------------------------------------------------
// pvrt_pkg
// types, codes and defaults shared by the page valid-range tracker
// ---------------------------------------------------------------------------
package pvrt_pkg;

  localparam int DEF_PAGE_SIZE = 4096;
  localparam int DEF_NUM_PAGES = 1024;

  localparam int CMD_W  = 2;
  localparam int PAGE_W = 10;
  localparam int OFS_W  = 12;
  localparam int CNT_W  = 13;
  localparam int RUN_W  = 13;
  localparam int CHG_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_MARK  = 2'd0,
    CMD_VALID = 2'd1,
    CMD_GAP   = 2'd2,
    CMD_INVAL = 2'd3
  } cmd_t;

  localparam logic [CHG_W-1:0] CHG_NONE    = 2'd0;
  localparam logic [CHG_W-1:0] CHG_UPDATED = 2'd1;
  localparam logic [CHG_W-1:0] CHG_DROPPED = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic clear_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ctrl_sts_t;

endpackage

@@ sv/pvrt_ram.sv @@
// ---------------------------------------------------------------------------
// pvrt_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
module pvrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/pvrt_ctrl.sv @@
// ---------------------------------------------------------------------------
// pvrt_ctrl
// sequencer: clearing pass, item accept, commit and result handshake
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pvrt_ctrl
  import pvrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd,
  input  ctrl_sts_t sts
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // commit once the result register is free or being drained
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    out_valid_next = cmd.commit | (out_valid & ~out_ready);
  end

  `ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready && state == ST_EXEC, "accept overlap")
  `ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid, "committed item not presented")
  `ASSERT_IMPL(a_no_accept_clear, in_ready, !cmd.clear_step, "accept during clearing pass")

endmodule

@@ sv/pvrt_dp.sv @@
// ---------------------------------------------------------------------------
// pvrt_dp
// range table, item registers, range update logic and result register
// ---------------------------------------------------------------------------
module pvrt_dp
  import pvrt_pkg::*;
#(
  parameter int PAGE_SIZE = DEF_PAGE_SIZE,
  parameter int NUM_PAGES = DEF_NUM_PAGES
) (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output ctrl_sts_t         sts,
  input  logic [CMD_W-1:0]  command,
  input  logic [PAGE_W-1:0] page_index,
  input  logic [OFS_W-1:0]  offset,
  input  logic [CNT_W-1:0]  req_count,
  output logic [RUN_W-1:0]  run_length,
  output logic [CHG_W-1:0]  change_code
);

  localparam int PW = $clog2(PAGE_SIZE + 1);
  localparam int VW = (PW > 14) ? PW : 14;
  localparam int EW = 4 * PW;
  localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam logic [VW-1:0] PSV = VW'(PAGE_SIZE);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PAGES - 1);

  // item registers
  cmd_t          cmd_q;
  logic [VW-1:0] s0;
  logic [VW-1:0] cnt;
  logic [AW-1:0] addr_q;
  logic          in_range_q;
  logic [AW-1:0] clr_addr;

  logic [VW-1:0] cnt_in;
  assign cnt_in = (VW'(req_count) > PSV) ? PSV : VW'(req_count);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q      <= cmd_t'(command);
      s0         <= VW'(offset);
      cnt        <= cnt_in;
      addr_q     <= AW'(page_index);
      in_range_q <= (32'(page_index) < NUM_PAGES) && (32'(offset) < PAGE_SIZE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= (clr_addr == LAST_ADDR) ? '0 : clr_addr + AW'(1);
    end
  end

  assign sts.clear_last = (clr_addr == LAST_ADDR);

  // range table
  logic [EW-1:0] rdata, wdata, new_entry;
  logic          we;
  logic [AW-1:0] waddr;

  assign we    = cmd.clear_step | (cmd.commit & in_range_q);
  assign waddr = cmd.clear_step ? clr_addr : addr_q;
  assign wdata = cmd.clear_step ? '0 : new_entry;

  pvrt_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_PAGES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.load),
    .raddr (AW'(page_index)),
    .rdata (rdata)
  );

  // range update
  logic [VW-1:0]    a0, a1, b0, b1, na0, na1, nb0, nb1;
  logic [VW-1:0]    sum, n, e, run;
  logic [CHG_W-1:0] code;

  always_comb begin
    a0  = VW'(rdata[4*PW-1:3*PW]);
    a1  = VW'(rdata[3*PW-1:2*PW]);
    b0  = VW'(rdata[2*PW-1:PW]);
    b1  = VW'(rdata[PW-1:0]);
    na0 = a0;
    na1 = a1;
    nb0 = b0;
    nb1 = b1;
    run  = '0;
    code = CHG_NONE;
    sum = s0 + cnt;
    n   = (sum < PSV) ? cnt : PSV - s0;
    e   = s0 + n;
    if (in_range_q) begin
      unique case (cmd_q)
        CMD_MARK: begin
          if (cnt != '0) begin
            run = n;
            if (!((a0 <= s0 && a1 >= e) || (b0 <= s0 && b1 >= e))) begin
              code = CHG_UPDATED;
              priority if (a1 == '0) begin
                na0 = s0;
                na1 = e;
              end else if (a0 <= e && a1 >= e) begin
                na0 = s0;
              end else if (a0 <= s0 && a1 >= s0) begin
                // grown range a reaching b takes b's end
                if (b0 != '0 && e >= b0) begin
                  na1 = b1;
                  nb0 = '0;
                  nb1 = '0;
                end else begin
                  na1 = e;
                end
              end else if (b0 != '0 && b0 <= e && b1 >= e) begin
                nb0 = s0;
              end else if (b0 != '0 && b0 <= s0 && b1 >= s0) begin
                nb1 = e;
              end else begin
                if (b0 != '0) begin
                  code = CHG_DROPPED;
                end
                if (a1 < s0) begin
                  nb0 = s0;
                  nb1 = e;
                end else begin
                  nb0 = a0;
                  nb1 = a1;
                  na0 = s0;
                  na1 = e;
                end
              end
            end
          end
        end
        CMD_VALID: begin
          priority if (a0 <= s0 && a1 > s0) begin
            run = (sum < a1) ? cnt : a1 - s0;
          end else if (b0 <= s0 && b1 > s0) begin
            run = (sum < b1) ? cnt : b1 - s0;
          end else begin
            run = '0;
          end
        end
        CMD_GAP: begin
          priority if ((a0 <= s0 && a1 > s0) || (b0 <= s0 && b1 > s0)) begin
            run = '0;
          end else if (a0 > s0) begin
            run = (sum < a0) ? cnt : a0 - s0;
          end else if (b0 > s0) begin
            run = (sum < b0) ? cnt : b0 - s0;
          end else if (b1 <= s0) begin
            run = n;
          end else begin
            run = '0;
          end
        end
        CMD_INVAL: begin
          priority if (a0 != '0 && s0 <= a0) begin
            na0 = '0;
            na1 = '0;
            nb0 = '0;
            nb1 = '0;
          end else if (s0 < a1) begin
            na1 = s0;
            nb0 = '0;
            nb1 = '0;
          end else if (b0 != '0 && s0 <= b0) begin
            nb0 = '0;
            nb1 = '0;
          end else if (s0 < b1) begin
            nb1 = s0;
          end else begin
            nb1 = b1;
          end
        end
        default: begin
          run = '0;
        end
      endcase
    end
    new_entry = {PW'(na0), PW'(na1), PW'(nb0), PW'(nb1)};
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      run_length  <= run[RUN_W-1:0];
      change_code <= code;
    end
  end

endmodule

@@ sv/page_valid_range_tracker.sv @@
// ---------------------------------------------------------------------------
// page_valid_range_tracker
// per-page tracking of two valid sample ranges with mark, lookup and
// invalidate operations
// ---------------------------------------------------------------------------
// timing: each item is a table read-modify-write; at accept the item is
//   registered and its entry read, and in the EXEC state the entry is
//   updated and written back and the result registered; a waiting result
//   holds this update step until it is taken, and no new item is accepted
//   before the last one has been committed
// reset: synchronous; afterwards a clearing pass writes every page empty,
//   during which no item is accepted
// ---------------------------------------------------------------------------
module page_valid_range_tracker
  import pvrt_pkg::*;
#(
  parameter int PAGE_SIZE = DEF_PAGE_SIZE,
  parameter int NUM_PAGES = DEF_NUM_PAGES
) (
  input  logic              clk,
  input  logic              rst,
  // item input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [PAGE_W-1:0] page_index,
  input  logic [OFS_W-1:0]  offset,
  input  logic [CNT_W-1:0]  req_count,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RUN_W-1:0]  run_length,
  output logic [CHG_W-1:0]  change_code
);

  // command and status between sequencer and datapath
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: clearing pass, accept, commit when the result slot is free
  pvrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: range table ram, update logic and result register
  pvrt_dp #(
    .PAGE_SIZE (PAGE_SIZE),
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .command      (command),
    .page_index   (page_index),
    .offset       (offset),
    .req_count    (req_count),
    .run_length   (run_length),
    .change_code  (change_code)
  );

endmodule
